// File: hw/rtl/keyword_number_bitstring_lexer_defines.svh
// Assertion macros used by the verification-side checker of the lexer.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef KEYWORD_NUMBER_BITSTRING_LEXER_DEFINES_SVH
`define KEYWORD_NUMBER_BITSTRING_LEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KNBL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyword_number_bitstring_lexer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KNBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyword_number_bitstring_lexer: next-cycle check failed");

`endif

// File: hw/rtl/knbl_pkg.sv
// Shared types and constants of the keyword/number/bitstring lexer.
// Used by the front, the queue, the back, the top level and the checker.
package knbl_pkg;

  // Source characters the lexer recognizes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_W     = 8'h77;

  // Queue between front and back; depth must be a power of two.
  localparam int KNBL_FIFO_DEPTH = 4;
  localparam int KNBL_PTR_W      = $clog2(KNBL_FIFO_DEPTH);

  typedef enum logic [3:0] {
    TAG_EOF    = 4'd0,
    TAG_OPEN   = 4'd1,
    TAG_CLOSE  = 4'd2,
    TAG_DOTDOT = 4'd3,
    TAG_SWAP   = 4'd4,
    TAG_SLICE  = 4'd5,
    TAG_INT    = 4'd6,
    TAG_BITS   = 4'd7,
    TAG_ERR    = 4'd8
  } tag_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DOT      = 3'd1,
    ERR_KEYWORD  = 3'd2,
    ERR_LEAD_ZERO = 3'd3,
    ERR_BITS_END = 3'd4,
    ERR_INVALID  = 3'd5
  } err_t;

  // One result piece.
  typedef struct packed {
    tag_t       tag;
    logic       has_char;
    logic [7:0] text_char;
    logic       done;
    err_t       err;
  } res_t;

  // Everything one source byte produces, if anything: one or two pieces.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pkt_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

endpackage

// File: hw/rtl/keyword_number_bitstring_lexer.sv
// Streaming lexer for parentheses, '..', the keywords swap and slice,
// decimal integers and quoted bit strings. One source byte per input beat.
//
// Input channel: in_valid/in_stall with in_char_byte. A beat is taken at a
// clock edge with in_valid high and in_stall low. One byte per cycle is
// accepted as long as the four-entry packet queue has room; in_stall is
// high only while that queue is full.
// Output channel: out_valid/out_stall with one result piece per beat.
// A piece passes through the packet queue and the output register.
// A byte yields zero, one or two pieces; two pieces (an integer end piece
// followed by the lexed terminating byte) leave on two consecutive beats,
// so the output, one piece per cycle unless stalled, sets the steady rate.
// out_last_of_item marks the final piece of each byte.
// While out_stall is high the output register holds its beat unchanged and
// the queue keeps absorbing input until it fills.
// After a lexical error the error piece is the last output; every later
// byte is accepted and dropped until reset.
// Reset (rst_n low, synchronous) empties the queue, marks the output
// register empty and returns the lexer to the between-tokens state.
// Depends on knbl_pkg, knbl_front, knbl_fifo and knbl_back.
module keyword_number_bitstring_lexer
  import knbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_tag,
  output logic       out_has_char,
  output logic [7:0] out_text_char,
  output logic       out_token_done,
  output logic [2:0] out_error_code,
  output logic       out_last_of_item
);

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  pkt_t       push_pkt;
  pkt_t       head_pkt;
  res_t       out_res;

  // Front: token state machine, one byte per cycle while the queue has room.
  knbl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char_byte(in_char_byte),
    .fifo_stat   (fifo_stat),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  // Queue of packets decouples the front from output back-pressure.
  knbl_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_pkt(push_pkt),
    .pop     (pop),
    .stat    (fifo_stat),
    .head_pkt(head_pkt)
  );

  // Back: splits packets into single result beats.
  knbl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fifo_stat(fifo_stat),
    .head_pkt (head_pkt),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res),
    .out_last (out_last_of_item)
  );

  assign out_token_tag  = out_res.tag;
  assign out_has_char   = out_res.has_char;
  assign out_text_char  = out_res.text_char;
  assign out_token_done = out_res.done;
  assign out_error_code = out_res.err;

endmodule

// File: hw/rtl/knbl_front.sv
// Front end of the lexer: takes source bytes, runs the token state machine
// and emits a packet of one or two result pieces. Depends on knbl_pkg.
module knbl_front
  import knbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  fifo_stat_t fifo_stat,
  output logic       push,
  output pkt_t       push_pkt
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_DOT  = 12'b0000_0000_0010,
    ST_S    = 12'b0000_0000_0100,
    ST_SW   = 12'b0000_0000_1000,
    ST_SWA  = 12'b0000_0001_0000,
    ST_SL   = 12'b0000_0010_0000,
    ST_SLI  = 12'b0000_0100_0000,
    ST_SLIC = 12'b0000_1000_0000,
    ST_INT  = 12'b0001_0000_0000,
    ST_ZERO = 12'b0010_0000_0000,
    ST_BITS = 12'b0100_0000_0000,
    ST_HALT = 12'b1000_0000_0000
  } lex_state_t;

  lex_state_t state_r, state_nxt;
  lex_state_t idle_nxt;
  logic       idle_emit;
  res_t       idle_res;
  logic       emit;
  logic       accept;
  logic       is_digit;
  logic       is_bit;
  pkt_t       pkt;

  function automatic res_t mk_res(tag_t tag, logic has, logic [7:0] ch, logic done,
                                  err_t err);
    res_t r;
    r.tag       = tag;
    r.has_char  = has;
    r.text_char = ch;
    r.done      = done;
    r.err       = err;
    return r;
  endfunction

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = in_char_byte inside {[CH_0:CH_9]};
  assign is_bit   = in_char_byte inside {CH_0, CH_1};

  // Lexing of a byte seen between tokens.
  always_comb begin
    idle_emit = 1'b1;
    idle_nxt  = ST_IDLE;
    idle_res  = mk_res(TAG_EOF, 1'b0, 8'h00, 1'b1, ERR_NONE);
    case (in_char_byte)
      CH_NUL:   idle_res = mk_res(TAG_EOF, 1'b0, 8'h00, 1'b1, ERR_NONE);
      CH_OPEN:  idle_res = mk_res(TAG_OPEN, 1'b0, 8'h00, 1'b1, ERR_NONE);
      CH_CLOSE: idle_res = mk_res(TAG_CLOSE, 1'b0, 8'h00, 1'b1, ERR_NONE);
      CH_DOT: begin
        idle_emit = 1'b0;
        idle_nxt  = ST_DOT;
      end
      CH_S: begin
        idle_emit = 1'b0;
        idle_nxt  = ST_S;
      end
      CH_QUOTE: begin
        idle_emit = 1'b0;
        idle_nxt  = ST_BITS;
      end
      CH_SPACE, CH_TAB: idle_emit = 1'b0;
      default: begin
        if (is_digit) begin
          idle_res = mk_res(TAG_INT, 1'b1, in_char_byte, 1'b0, ERR_NONE);
          idle_nxt = (in_char_byte == CH_0) ? ST_ZERO : ST_INT;
        end else begin
          idle_res = mk_res(TAG_ERR, 1'b0, 8'h00, 1'b1, ERR_INVALID);
          idle_nxt = ST_HALT;
        end
      end
    endcase
  end

  // Token state machine; any failure sends it to the halt state.
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    pkt.two   = 1'b0;
    pkt.r0    = mk_res(TAG_ERR, 1'b0, 8'h00, 1'b1, ERR_KEYWORD);
    pkt.r1    = idle_res;
    case (state_r)
      ST_IDLE: begin
        emit      = idle_emit;
        pkt.r0    = idle_res;
        state_nxt = idle_nxt;
      end
      ST_DOT: begin
        emit = 1'b1;
        if (in_char_byte == CH_DOT) begin
          pkt.r0    = mk_res(TAG_DOTDOT, 1'b0, 8'h00, 1'b1, ERR_NONE);
          state_nxt = ST_IDLE;
        end else begin
          pkt.r0    = mk_res(TAG_ERR, 1'b0, 8'h00, 1'b1, ERR_DOT);
          state_nxt = ST_HALT;
        end
      end
      ST_S: begin
        if (in_char_byte == CH_W) begin
          state_nxt = ST_SW;
        end else if (in_char_byte == CH_L) begin
          state_nxt = ST_SL;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_HALT;
        end
      end
      ST_SW: begin
        if (in_char_byte == CH_A) begin
          state_nxt = ST_SWA;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_HALT;
        end
      end
      ST_SL: begin
        if (in_char_byte == CH_I) begin
          state_nxt = ST_SLI;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_HALT;
        end
      end
      ST_SLI: begin
        if (in_char_byte == CH_C) begin
          state_nxt = ST_SLIC;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_HALT;
        end
      end
      ST_SWA: begin
        emit = 1'b1;
        if (in_char_byte == CH_P) begin
          pkt.r0    = mk_res(TAG_SWAP, 1'b0, 8'h00, 1'b1, ERR_NONE);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HALT;
        end
      end
      ST_SLIC: begin
        emit = 1'b1;
        if (in_char_byte == CH_E) begin
          pkt.r0    = mk_res(TAG_SLICE, 1'b0, 8'h00, 1'b1, ERR_NONE);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HALT;
        end
      end
      ST_INT, ST_ZERO: begin
        emit = 1'b1;
        if (is_digit) begin
          if (state_r == ST_ZERO) begin
            pkt.r0    = mk_res(TAG_ERR, 1'b0, 8'h00, 1'b1, ERR_LEAD_ZERO);
            state_nxt = ST_HALT;
          end else begin
            pkt.r0 = mk_res(TAG_INT, 1'b1, in_char_byte, 1'b0, ERR_NONE);
          end
        end else begin
          // The integer closes and the terminating byte is lexed on its own.
          pkt.r0    = mk_res(TAG_INT, 1'b0, 8'h00, 1'b1, ERR_NONE);
          pkt.two   = idle_emit;
          state_nxt = idle_nxt;
        end
      end
      ST_BITS: begin
        emit = 1'b1;
        if (is_bit) begin
          pkt.r0 = mk_res(TAG_BITS, 1'b1, in_char_byte, 1'b0, ERR_NONE);
        end else if (in_char_byte == CH_QUOTE) begin
          pkt.r0    = mk_res(TAG_BITS, 1'b0, 8'h00, 1'b1, ERR_NONE);
          state_nxt = ST_IDLE;
        end else begin
          pkt.r0    = mk_res(TAG_ERR, 1'b0, 8'h00, 1'b1, ERR_BITS_END);
          state_nxt = ST_HALT;
        end
      end
      default: state_nxt = ST_HALT;
    endcase
  end

  assign push     = accept && emit;
  assign push_pkt = pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/knbl_fifo.sv
// Short packet queue between the lexer front and back.
// Depends on knbl_pkg for the packet type and depth.
module knbl_fifo
  import knbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pkt_t       push_pkt,
  input  logic       pop,
  output fifo_stat_t stat,
  output pkt_t       head_pkt
);

  pkt_t                  mem_r [KNBL_FIFO_DEPTH];
  logic [KNBL_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [KNBL_PTR_W:0]   count_r;
  logic                  do_push, do_pop;

  assign stat.full  = (count_r == (KNBL_PTR_W + 1)'(KNBL_FIFO_DEPTH));
  assign stat.valid = (count_r != '0);
  assign head_pkt   = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/knbl_back.sv
// Back end of the lexer: unpacks queued packets into single result beats
// held in an output register. Depends on knbl_pkg.
module knbl_back
  import knbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t fifo_stat,
  input  pkt_t       head_pkt,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_res,
  output logic       out_last
);

  logic out_valid_r;
  logic phase_r;
  res_t res_r;
  logic last_r;
  logic load;
  logic last_nxt;

  // The output register may be refilled when it is empty or being taken.
  assign load     = fifo_stat.valid && (!out_valid_r || !out_stall);
  assign last_nxt = phase_r || !head_pkt.two;
  assign pop      = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      phase_r     <= !last_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= phase_r ? head_pkt.r1 : head_pkt.r0;
      last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

// File: hw/rtl/knbl_checker.sv
// Port-level checks of the lexer, bound to the top level.
// Depends on knbl_pkg and keyword_number_bitstring_lexer_defines.svh.
`include "keyword_number_bitstring_lexer_defines.svh"

module knbl_checker
  import knbl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_token_tag,
  input logic       out_has_char,
  input logic [7:0] out_text_char,
  input logic       out_token_done,
  input logic [2:0] out_error_code,
  input logic       out_last_of_item
);

  // A stalled result beat stays put.
  `KNBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_token_tag) && $stable(out_text_char) && $stable(out_token_done) && $stable(out_last_of_item))

  // An error code appears exactly on error pieces.
  `KNBL_ASSERT_IMPL(a_err_code, out_valid, (out_token_tag == TAG_ERR) == (out_error_code != ERR_NONE))

  // Echoed characters belong to open integer or bit-string tokens.
  `KNBL_ASSERT_IMPL(a_echo, out_valid && out_has_char, !out_token_done && (out_token_tag == TAG_INT || out_token_tag == TAG_BITS))

  // No beat directly follows a delivered error piece.
  `KNBL_ASSERT_NEXT(a_halt, out_valid && !out_stall && out_token_tag == TAG_ERR, !out_valid)

endmodule

bind keyword_number_bitstring_lexer knbl_checker u_knbl_checker (.*);
